FILE: src/rrv_pkg.sv
// Shared types, constants and the arctangent table of the rounded rectangle vertex generator.
package rrv_pkg;

  localparam int IN_W  = 24;   // signed position width
  localparam int SZ_W  = 23;   // unsigned size and radius width
  localparam int OUT_W = 25;   // signed output coordinate width
  localparam int CW    = 27;   // internal edge and vertex width
  localparam int UR_W  = 22;   // capped radius width

  localparam int MAX_ARC_POINTS = 32;
  localparam int IDX_W          = $clog2(MAX_ARC_POINTS);
  localparam int MIN_PTS        = 4;

  // Points per corner: 4 + floor((ur - 768) / 1344), at most 28 steps above the minimum.
  localparam logic [UR_W-1:0] MAP_LO        = UR_W'(768);
  localparam logic [UR_W-1:0] MAP_STEP      = UR_W'(1344);
  localparam logic [IDX_W-1:0] MAP_MAX_STEPS = IDX_W'(MAX_ARC_POINTS - MIN_PTS);

  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ANG_W        = 31;   // angle in unsigned Q1.30 quarter turns, at most one quarter turn
  localparam int ZW           = 33;   // CORDIC working width
  localparam int CS_W         = 32;   // stored cosine and sine width
  localparam logic signed [ZW-1:0] CORDIC_GAIN = ZW'(652032875);

  localparam int QUO_SH = 30;         // a quarter turn is 2^30
  localparam int NUM_W  = IDX_W + QUO_SH;

  typedef logic signed [CW-1:0] coord_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [STEP_W-1:0] k);
    logic signed [ZW-1:0] v;
    case (k)
      5'd0:  v = ZW'(536870912);
      5'd1:  v = ZW'(316933406);
      5'd2:  v = ZW'(167458907);
      5'd3:  v = ZW'(85004756);
      5'd4:  v = ZW'(42667331);
      5'd5:  v = ZW'(21354465);
      5'd6:  v = ZW'(10679838);
      5'd7:  v = ZW'(5340245);
      5'd8:  v = ZW'(2670163);
      5'd9:  v = ZW'(1335087);
      5'd10: v = ZW'(667544);
      5'd11: v = ZW'(333772);
      5'd12: v = ZW'(166886);
      5'd13: v = ZW'(83443);
      5'd14: v = ZW'(41722);
      5'd15: v = ZW'(20861);
      5'd16: v = ZW'(10430);
      5'd17: v = ZW'(5215);
      5'd18: v = ZW'(2608);
      5'd19: v = ZW'(1304);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/rrv_div.sv
// Restoring divider, one quotient bit per cycle, for the arc point angles.
module rrv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rrv_pkg::NUM_W-1:0]   num,
  input  logic [rrv_pkg::IDX_W-1:0]   den,
  output logic                        done,
  output logic [rrv_pkg::ANG_W-1:0]   quo
);
  import rrv_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  rem_r;
  logic [NUM_W-1:0]  nq_r;
  logic [IDX_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, nq_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CNT_W'(NUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      nq_r  <= num;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (qbit) begin
        rem_r <= IDX_W'(trial - {1'b0, den});
      end else begin
        rem_r <= trial[IDX_W-1:0];
      end
      nq_r <= {nq_r[NUM_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = nq_r[ANG_W-1:0];

endmodule

FILE: src/rrv_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.30, one step per cycle.
module rrv_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rrv_pkg::ANG_W-1:0]         angle,
  output logic                              done,
  output logic signed [rrv_pkg::CS_W-1:0]   cos_q,
  output logic signed [rrv_pkg::CS_W-1:0]   sin_q
);
  import rrv_pkg::*;

  logic                    run_r;
  logic                    done_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [ZW-1:0]    x_r, y_r, z_r;
  logic signed [ZW-1:0]    dx, dy, at;

  // Arithmetic shifts floor towards minus infinity, as the iteration requires.
  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign at = atan_val(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({{(ZW-ANG_W){1'b0}}, angle});
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
      if (!z_r[ZW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign cos_q = x_r[CS_W-1:0];
  assign sin_q = y_r[CS_W-1:0];

endmodule

FILE: src/rounded_rect_vertex_gen_core.sv
// Top level of the rounded rectangle vertex generator: sequencer, arc table and vertex datapath.
//
//   channel   ports                              handshake
//   -------   --------------------------------   ---------------------------------
//   request   in_pos_x/y, in_width/height/radius  taken when start and not busy
//   result    out_first_x/y, out_second_x/y,      one cycle, marked by out_valid
//             out_last_pair
//   config    cfg_center_mode                     written when cfg_valid, cfg_ready
//
// A request with zero radius gives its two results from states ST_SH0 and ST_SH1. Otherwise the
// block fills an arc table: per point one angle division and one CORDIC run, then passes
// each vertex through ST_RD, ST_MX, ST_MY and ST_VW, using the shared multiplier for x and y.
// busy is high throughout. Reset clears the sequencer and the centre mode; the receiver
// cannot stall results.
module rounded_rect_vertex_gen_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rrv_pkg::IN_W-1:0]    in_pos_x,
  input  logic signed [rrv_pkg::IN_W-1:0]    in_pos_y,
  input  logic [rrv_pkg::SZ_W-1:0]           in_width,
  input  logic [rrv_pkg::SZ_W-1:0]           in_height,
  input  logic [rrv_pkg::SZ_W-1:0]           in_radius,
  output logic                               out_valid,
  output logic signed [rrv_pkg::OUT_W-1:0]   out_first_x,
  output logic signed [rrv_pkg::OUT_W-1:0]   out_first_y,
  output logic signed [rrv_pkg::OUT_W-1:0]   out_second_x,
  output logic signed [rrv_pkg::OUT_W-1:0]   out_second_y,
  output logic                               out_last_pair,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_center_mode
);
  import rrv_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EDGE = 4'd1;
  localparam logic [3:0] ST_PRE  = 4'd2;
  localparam logic [3:0] ST_MAP  = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_DIVW = 4'd5;
  localparam logic [3:0] ST_COR  = 4'd6;
  localparam logic [3:0] ST_CORW = 4'd7;
  localparam logic [3:0] ST_RD   = 4'd8;
  localparam logic [3:0] ST_MX   = 4'd9;
  localparam logic [3:0] ST_MY   = 4'd10;
  localparam logic [3:0] ST_VW   = 4'd11;
  localparam logic [3:0] ST_SH0  = 4'd12;
  localparam logic [3:0] ST_SH1  = 4'd13;

  localparam int PROD_W = UR_W + 1 + CS_W;
  localparam int RND_W  = PROD_W - QUO_SH;

  logic [3:0]             state_r, state_nxt;
  logic                   center_mode_r;
  logic                   out_valid_r, out_valid_nxt;

  coord_t                 l_r, t_r, r_r, b_r;
  coord_t                 xr_r, xl_r, yt_r, yb_r;
  logic [SZ_W-1:0]        w_r, h_r, rq_r;
  logic [UR_W-1:0]        ur_r;
  logic [UR_W-1:0]        map_d_r;
  logic [IDX_W-1:0]       map_cnt_r;
  logic                   small_r;
  logic [IDX_W-1:0]       cp_m1_r;
  logic [IDX_W-1:0]       i_r;
  logic [1:0]             q_r;
  logic                   half_r;
  logic [ANG_W-1:0]       angle_r;
  logic signed [PROD_W-1:0] prod_r;
  coord_t                 vx_r;
  coord_t                 fx_r, fy_r;

  logic signed [OUT_W-1:0] ofx_r, ofy_r, osx_r, osy_r;
  logic                   olast_r;

  logic [2*CS_W-1:0]      arc_mem [MAX_ARC_POINTS];
  logic [2*CS_W-1:0]      rd_r;

  logic                   div_done, cor_done;
  logic [ANG_W-1:0]       div_quo;
  logic signed [CS_W-1:0] cor_c, cor_s;

  logic                   last_i;
  logic                   map_go;
  logic [SZ_W-2:0]        half_min;
  logic signed [CS_W-1:0] rd_c, rd_s, csel, ssel;
  logic signed [PROD_W-1:0] rnd_sum;
  coord_t                 rnd_v;
  coord_t                 base_x, base_y, vy;
  coord_t                 l_in, t_in;

  assign last_i   = (i_r == cp_m1_r);
  assign map_go   = (map_d_r >= MAP_STEP) && (map_cnt_r != MAP_MAX_STEPS);
  assign half_min = (w_r < h_r) ? w_r[SZ_W-1:1] : h_r[SZ_W-1:1];
  assign rd_c     = rd_r[2*CS_W-1:CS_W];
  assign rd_s     = rd_r[CS_W-1:0];

  // Each quadrant reuses the first quadrant's table with swapped or negated terms.
  always_comb begin
    case (q_r)
      2'd0: begin csel = rd_c;  ssel = rd_s;  end
      2'd1: begin csel = -rd_s; ssel = rd_c;  end
      2'd2: begin csel = -rd_c; ssel = -rd_s; end
      default: begin csel = rd_s; ssel = -rd_c; end
    endcase
  end

  assign base_x  = (q_r == 2'd1 || q_r == 2'd2) ? xl_r : xr_r;
  assign base_y  = (q_r[1]) ? yb_r : yt_r;
  assign rnd_sum = prod_r + (PROD_W'(1) <<< (QUO_SH - 1));
  assign rnd_v   = CW'($signed(rnd_sum[PROD_W-1:QUO_SH]));
  assign vy      = base_y - rnd_v;

  assign l_in = CW'(in_pos_x) - (center_mode_r ? CW'(in_width[SZ_W-1:1]) : '0);
  assign t_in = CW'(in_pos_y) - (center_mode_r ? CW'(in_height[SZ_W-1:1]) : '0);

  rrv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIV),
    .num   ({i_r, {QUO_SH{1'b0}}} + NUM_W'(cp_m1_r[IDX_W-1:1])),
    .den   (cp_m1_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  rrv_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_COR),
    .angle (angle_r),
    .done  (cor_done),
    .cos_q (cor_c),
    .sin_q (cor_s)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EDGE;
      ST_EDGE: state_nxt = (rq_r == '0) ? ST_SH0 : ST_PRE;
      ST_PRE:  state_nxt = ST_MAP;
      ST_MAP:  if (small_r || !map_go) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_DIVW;
      ST_DIVW: if (div_done) state_nxt = ST_COR;
      ST_COR:  state_nxt = ST_CORW;
      ST_CORW: if (cor_done) state_nxt = last_i ? ST_RD : ST_DIV;
      ST_RD:   state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_VW;
      ST_VW:   state_nxt = (last_i && q_r == 2'd3) ? ST_IDLE : ST_RD;
      ST_SH0:  state_nxt = ST_SH1;
      ST_SH1:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (state_r == ST_VW && half_r) || state_r == ST_SH0 ||
                         state_r == ST_SH1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      center_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        center_mode_r <= cfg_center_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CORW && cor_done) begin
      arc_mem[i_r] <= {cor_c, cor_s};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= arc_mem[i_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          l_r  <= l_in;
          t_r  <= t_in;
          w_r  <= in_width;
          h_r  <= in_height;
          rq_r <= in_radius;
        end
      end
      ST_EDGE: begin
        r_r  <= l_r + CW'(w_r);
        b_r  <= t_r + CW'(h_r);
        ur_r <= ({1'b0, half_min} > rq_r) ? rq_r[UR_W-1:0] : half_min;
      end
      ST_PRE: begin
        map_d_r   <= ur_r - MAP_LO;
        map_cnt_r <= '0;
        small_r   <= (ur_r < MAP_LO);
        xr_r      <= r_r - CW'(ur_r);
        xl_r      <= l_r + CW'(ur_r);
        yt_r      <= t_r + CW'(ur_r);
        yb_r      <= b_r - CW'(ur_r);
      end
      ST_MAP: begin
        if (!small_r && map_go) begin
          map_d_r   <= map_d_r - MAP_STEP;
          map_cnt_r <= map_cnt_r + 1'b1;
        end else begin
          cp_m1_r <= small_r ? IDX_W'(MIN_PTS - 1) : map_cnt_r + IDX_W'(MIN_PTS - 1);
          i_r     <= '0;
        end
      end
      ST_DIVW: begin
        if (div_done) angle_r <= div_quo;
      end
      ST_CORW: begin
        if (cor_done) begin
          if (last_i) begin
            i_r    <= '0;
            q_r    <= 2'd0;
            half_r <= 1'b0;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
      end
      ST_MX: begin
        prod_r <= $signed({1'b0, ur_r}) * csel;
      end
      ST_MY: begin
        vx_r   <= base_x + rnd_v;
        prod_r <= $signed({1'b0, ur_r}) * ssel;
      end
      ST_VW: begin
        if (!half_r) begin
          fx_r   <= vx_r;
          fy_r   <= vy;
          half_r <= 1'b1;
        end else begin
          ofx_r   <= fx_r[OUT_W-1:0];
          ofy_r   <= fy_r[OUT_W-1:0];
          osx_r   <= vx_r[OUT_W-1:0];
          osy_r   <= vy[OUT_W-1:0];
          olast_r <= last_i && q_r == 2'd3;
          half_r  <= 1'b0;
        end
        if (last_i) begin
          i_r <= '0;
          q_r <= q_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      ST_SH0: begin
        ofx_r   <= l_r[OUT_W-1:0];
        ofy_r   <= t_r[OUT_W-1:0];
        osx_r   <= r_r[OUT_W-1:0];
        osy_r   <= t_r[OUT_W-1:0];
        olast_r <= 1'b0;
      end
      ST_SH1: begin
        ofx_r   <= r_r[OUT_W-1:0];
        ofy_r   <= b_r[OUT_W-1:0];
        osx_r   <= l_r[OUT_W-1:0];
        osy_r   <= b_r[OUT_W-1:0];
        olast_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_first_x   = ofx_r;
  assign out_first_y   = ofy_r;
  assign out_second_x  = osx_r;
  assign out_second_y  = osy_r;
  assign out_last_pair = olast_r;

endmodule
